// ===== rtl/strm_pkg.sv =====
// ---------------------------------------------------------------------------
// strm_pkg
// shared widths, codes, control word layout and the microcode rom
// ---------------------------------------------------------------------------
package strm_pkg;

	localparam int POS_W = 10;
	localparam int VAL_W = 31;

	localparam logic [VAL_W-1:0] EMPTY_VALUE = 31'h7fff_ffff;

	// sequencer step codes
	localparam int PC_W = 4;
	localparam logic [PC_W-1:0] ST_CLEAR   = 4'd0;
	localparam logic [PC_W-1:0] ST_FETCH   = 4'd1;
	localparam logic [PC_W-1:0] ST_DECODE  = 4'd2;
	localparam logic [PC_W-1:0] ST_U_CHECK = 4'd3;
	localparam logic [PC_W-1:0] ST_U_LEAF  = 4'd4;
	localparam logic [PC_W-1:0] ST_U_CLIMB = 4'd5;
	localparam logic [PC_W-1:0] ST_Q_INIT  = 4'd6;
	localparam logic [PC_W-1:0] ST_Q_CLIMB = 4'd7;
	localparam logic [PC_W-1:0] ST_Q_EMIT  = 4'd8;

	// jump conditions
	localparam logic [3:0] C_ALWAYS      = 4'd0;
	localparam logic [3:0] C_CLR_LAST    = 4'd1;
	localparam logic [3:0] C_IN_FIRE     = 4'd2;
	localparam logic [3:0] C_IS_QUERY    = 4'd3;
	localparam logic [3:0] C_POS_BAD     = 4'd4;
	localparam logic [3:0] C_LEAF_ROOT   = 4'd5;
	localparam logic [3:0] C_PARENT_ROOT = 4'd6;
	localparam logic [3:0] C_RANGE_EMPTY = 4'd7;
	localparam logic [3:0] C_AB_NEXT_OK  = 4'd8;
	localparam logic [3:0] C_OUT_BUSY    = 4'd9;

	// write address / data source
	localparam logic [1:0] WA_CLEAR  = 2'd0;
	localparam logic [1:0] WA_LEAF   = 2'd1;
	localparam logic [1:0] WA_PARENT = 2'd2;

	// read address source
	localparam logic [1:0] RA_LEAF_SIB   = 2'd0;
	localparam logic [1:0] RA_PARENT_SIB = 2'd1;
	localparam logic [1:0] RA_AB_LOAD    = 2'd2;
	localparam logic [1:0] RA_AB_NEXT    = 2'd3;

	localparam logic NODE_LEAF   = 1'b0;
	localparam logic NODE_PARENT = 1'b1;
	localparam logic AB_LOAD     = 1'b0;
	localparam logic AB_NEXT     = 1'b1;
	localparam logic BEST_INIT   = 1'b0;
	localparam logic BEST_FOLD   = 1'b1;

	typedef struct packed {
		logic       take;
		logic       emit;
		logic       mem_we;
		logic [1:0] waddr_sel;
		logic [1:0] raddr_sel;
		logic       node_en;
		logic       node_sel;
		logic       ab_en;
		logic       ab_sel;
		logic       best_en;
		logic       best_sel;
		logic       clr_en;
	} ctl_t;

	typedef struct packed {
		logic clr_last;
		logic in_fire;
		logic is_query;
		logic pos_bad;
		logic leaf_root;
		logic parent_root;
		logic range_empty;
		logic ab_next_ok;
		logic out_busy;
	} status_t;

	typedef struct packed {
		ctl_t            ctl;
		logic [3:0]      cond;
		logic [PC_W-1:0] next_t;
		logic [PC_W-1:0] next_f;
	} uword_t;

	function automatic uword_t ucode_rom(input logic [PC_W-1:0] pc);
		uword_t w;
		w = '0;
		case (pc)
			ST_CLEAR: begin
				w.ctl.mem_we    = 1'b1;
				w.ctl.waddr_sel = WA_CLEAR;
				w.ctl.clr_en    = 1'b1;
				w.cond          = C_CLR_LAST;
				w.next_t        = ST_FETCH;
				w.next_f        = ST_CLEAR;
			end
			ST_FETCH: begin
				w.ctl.take = 1'b1;
				w.cond     = C_IN_FIRE;
				w.next_t   = ST_DECODE;
				w.next_f   = ST_FETCH;
			end
			ST_DECODE: begin
				w.cond   = C_IS_QUERY;
				w.next_t = ST_Q_INIT;
				w.next_f = ST_U_CHECK;
			end
			ST_U_CHECK: begin
				w.cond   = C_POS_BAD;
				w.next_t = ST_FETCH;
				w.next_f = ST_U_LEAF;
			end
			ST_U_LEAF: begin
				w.ctl.mem_we    = 1'b1;
				w.ctl.waddr_sel = WA_LEAF;
				w.ctl.raddr_sel = RA_LEAF_SIB;
				w.ctl.node_en   = 1'b1;
				w.ctl.node_sel  = NODE_LEAF;
				w.cond          = C_LEAF_ROOT;
				w.next_t        = ST_FETCH;
				w.next_f        = ST_U_CLIMB;
			end
			ST_U_CLIMB: begin
				w.ctl.mem_we    = 1'b1;
				w.ctl.waddr_sel = WA_PARENT;
				w.ctl.raddr_sel = RA_PARENT_SIB;
				w.ctl.node_en   = 1'b1;
				w.ctl.node_sel  = NODE_PARENT;
				w.cond          = C_PARENT_ROOT;
				w.next_t        = ST_FETCH;
				w.next_f        = ST_U_CLIMB;
			end
			ST_Q_INIT: begin
				w.ctl.raddr_sel = RA_AB_LOAD;
				w.ctl.ab_en     = 1'b1;
				w.ctl.ab_sel    = AB_LOAD;
				w.ctl.best_en   = 1'b1;
				w.ctl.best_sel  = BEST_INIT;
				w.cond          = C_RANGE_EMPTY;
				w.next_t        = ST_Q_EMIT;
				w.next_f        = ST_Q_CLIMB;
			end
			ST_Q_CLIMB: begin
				w.ctl.raddr_sel = RA_AB_NEXT;
				w.ctl.ab_en     = 1'b1;
				w.ctl.ab_sel    = AB_NEXT;
				w.ctl.best_en   = 1'b1;
				w.ctl.best_sel  = BEST_FOLD;
				w.cond          = C_AB_NEXT_OK;
				w.next_t        = ST_Q_CLIMB;
				w.next_f        = ST_Q_EMIT;
			end
			ST_Q_EMIT: begin
				w.ctl.emit = 1'b1;
				w.cond     = C_OUT_BUSY;
				w.next_t   = ST_Q_EMIT;
				w.next_f   = ST_FETCH;
			end
			default: begin
				w.cond   = C_ALWAYS;
				w.next_t = ST_FETCH;
				w.next_f = ST_FETCH;
			end
		endcase
		return w;
	endfunction

endpackage

// ===== rtl/strm_req_if.sv =====
// ---------------------------------------------------------------------------
// strm_req_if
// request channel: update or range query word with valid/ready
// ---------------------------------------------------------------------------
interface strm_req_if;
	import strm_pkg::*;

	logic             valid;
	logic             ready;
	logic             opcode;
	logic [POS_W-1:0] position;
	logic [VAL_W-1:0] new_value;
	logic [POS_W-1:0] range_low;
	logic [POS_W-1:0] range_high;

	modport source (
		output valid, opcode, position, new_value, range_low, range_high,
		input  ready
	);

	modport sink (
		input  valid, opcode, position, new_value, range_low, range_high,
		output ready
	);

endinterface

// ===== rtl/strm_rsp_if.sv =====
// ---------------------------------------------------------------------------
// strm_rsp_if
// response channel: range minimum word with valid/ready
// ---------------------------------------------------------------------------
interface strm_rsp_if;
	import strm_pkg::*;

	logic             valid;
	logic             ready;
	logic [VAL_W-1:0] minimum;
	logic             none_found;

	modport source (
		output valid, minimum, none_found,
		input  ready
	);

	modport sink (
		input  valid, minimum, none_found,
		output ready
	);

endinterface

// ===== rtl/segment_tree_range_min_top.sv =====
// ---------------------------------------------------------------------------
// segment_tree_range_min_top
// range-minimum segment tree driven by a microcoded step sequencer
// ---------------------------------------------------------------------------
// req takes one word per item: opcode 0 writes new_value to leaf position and
// refreshes its ancestors, opcode 1 asks for the minimum over leaves
// range_low..range_high with the end clamped to the last leaf
// updates give no rsp word, each query gives exactly one, in order
// 2147483647 marks an empty leaf; an empty or all-empty range returns it
// with none_found set
// steps, with L = log2 of the padded leaf count (10 by default)
//   update: one store write per level, leaf to root, then the next word is taken
//   query: k climb steps with 0 <= k <= L + 1, then the emit step; ready rises
//   with rsp valid, and the next word can then be taken
// reset: control clears at once, then a sweep writes empty into all
// 2 * padded-leaves nodes, one per cycle (2048 by default), with ready low
// stall: a waiting rsp word does not block the next request; a later query
// holds in its emit step until the rsp register frees up
// ---------------------------------------------------------------------------
module segment_tree_range_min_top #(
	parameter int LEAVES = 1024
) (
	input  logic       clk,
	input  logic       arst_n,
	strm_req_if.sink   req,
	strm_rsp_if.source rsp
);
	import strm_pkg::*;

	// control word from the rom and datapath conditions back to the sequencer
	ctl_t    ctl;
	status_t status;

	// step counter, rom and jump logic
	strm_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.ctl    (ctl)
	);

	// node store, pointers, min units and the response register
	strm_dp #(
		.LEAVES (LEAVES)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.status (status),
		.req    (req),
		.rsp    (rsp)
	);

endmodule

// ===== rtl/strm_seq.sv =====
// ---------------------------------------------------------------------------
// strm_seq
// step counter and rom lookup with two-way conditional jump
// ---------------------------------------------------------------------------
module strm_seq (
	input  logic              clk,
	input  logic              arst_n,
	input  strm_pkg::status_t status,
	output strm_pkg::ctl_t    ctl
);
	import strm_pkg::*;

	logic [PC_W-1:0] pc_q;
	logic [PC_W-1:0] pc_d;
	uword_t          uw;
	logic            cond_hit;

	always_comb begin
		uw = ucode_rom(pc_q);
		case (uw.cond)
			C_ALWAYS:      cond_hit = 1'b1;
			C_CLR_LAST:    cond_hit = status.clr_last;
			C_IN_FIRE:     cond_hit = status.in_fire;
			C_IS_QUERY:    cond_hit = status.is_query;
			C_POS_BAD:     cond_hit = status.pos_bad;
			C_LEAF_ROOT:   cond_hit = status.leaf_root;
			C_PARENT_ROOT: cond_hit = status.parent_root;
			C_RANGE_EMPTY: cond_hit = status.range_empty;
			C_AB_NEXT_OK:  cond_hit = status.ab_next_ok;
			C_OUT_BUSY:    cond_hit = status.out_busy;
			default:       cond_hit = 1'b1;
		endcase
		pc_d = cond_hit ? uw.next_t : uw.next_f;
	end

	assign ctl = uw.ctl;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= ST_CLEAR;
		end else begin
			pc_q <= pc_d;
		end
	end

endmodule

// ===== rtl/strm_dp.sv =====
// ---------------------------------------------------------------------------
// strm_dp
// node store, climb pointers, min logic and response register
// ---------------------------------------------------------------------------
module strm_dp #(
	parameter int LEAVES = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	input  strm_pkg::ctl_t    ctl,
	output strm_pkg::status_t status,
	strm_req_if.sink          req,
	strm_rsp_if.source        rsp
);
	import strm_pkg::*;

	localparam int PAD   = 1 << $clog2(LEAVES);
	localparam int DEPTH = 2 * PAD;
	localparam int NW    = $clog2(DEPTH);
	localparam int QW    = (NW > POS_W) ? NW : POS_W;

	// latched request word
	logic             op_q;
	logic [POS_W-1:0] pos_q;
	logic [VAL_W-1:0] val_q;
	logic [POS_W-1:0] lo_q;
	logic [POS_W-1:0] hi_q;

	logic [VAL_W-1:0] store [DEPTH];
	logic [VAL_W-1:0] rd0_q;
	logic [VAL_W-1:0] rd1_q;

	logic [NW-1:0]    clr_q;
	logic [NW-1:0]    node_q;
	logic [VAL_W-1:0] cur_q;
	logic [NW-1:0]    a_q;
	logic [NW-1:0]    b_q;
	logic [VAL_W-1:0] best_q;

	logic             rsp_valid_q;
	logic [VAL_W-1:0] rsp_min_q;
	logic             rsp_none_q;

	logic             in_fire;
	logic             out_busy;
	logic             emit_fire;
	logic [NW-1:0]    leaf_node;
	logic [NW-1:0]    par;
	logic [VAL_W-1:0] par_val;
	logic [QW-1:0]    hi_clamp;
	logic             range_empty;
	logic [NW-1:0]    a_load;
	logic [NW-1:0]    b_load;
	logic [NW:0]      a_inc;
	logic [NW-1:0]    b_dec;
	logic [NW-1:0]    a_next;
	logic [NW-1:0]    b_next;
	logic [VAL_W-1:0] cand_a;
	logic [VAL_W-1:0] cand_b;
	logic [VAL_W-1:0] cand_min;
	logic [VAL_W-1:0] best_fold;
	logic             mem_we;
	logic [NW-1:0]    waddr;
	logic [VAL_W-1:0] wdata;
	logic [NW-1:0]    raddr0;
	logic [NW-1:0]    raddr1;

	assign in_fire   = ctl.take && req.valid;
	assign out_busy  = rsp_valid_q && !rsp.ready;
	assign emit_fire = ctl.emit && !out_busy;
	assign req.ready = ctl.take;

	// update climb
	assign leaf_node = NW'(PAD) + NW'(pos_q);
	assign par       = node_q >> 1;
	assign par_val   = (rd0_q < cur_q) ? rd0_q : cur_q;

	// query set-up, end clamped to the last leaf
	assign hi_clamp    = (32'(hi_q) >= 32'(LEAVES)) ? QW'(LEAVES - 1) : QW'(hi_q);
	assign range_empty = QW'(lo_q) > hi_clamp;
	assign a_load      = NW'(PAD) + NW'(lo_q);
	assign b_load      = NW'(PAD) + NW'(hi_clamp);

	// two-pointer step: odd left and even right nodes fold in
	assign a_inc     = {1'b0, a_q} + (NW + 1)'(a_q[0]);
	assign b_dec     = b_q - NW'(!b_q[0]);
	assign a_next    = NW'(a_inc >> 1);
	assign b_next    = b_dec >> 1;
	assign cand_a    = a_q[0] ? rd0_q : EMPTY_VALUE;
	assign cand_b    = b_q[0] ? EMPTY_VALUE : rd1_q;
	assign cand_min  = (cand_b < cand_a) ? cand_b : cand_a;
	assign best_fold = (cand_min < best_q) ? cand_min : best_q;

	always_comb begin
		mem_we = ctl.mem_we;
		case (ctl.waddr_sel)
			WA_CLEAR: begin
				waddr = clr_q;
				wdata = EMPTY_VALUE;
			end
			WA_LEAF: begin
				waddr = leaf_node;
				wdata = val_q;
			end
			WA_PARENT: begin
				waddr = par;
				wdata = par_val;
			end
			default: begin
				mem_we = 1'b0;
				waddr  = clr_q;
				wdata  = EMPTY_VALUE;
			end
		endcase
		case (ctl.raddr_sel)
			RA_LEAF_SIB: begin
				raddr0 = leaf_node ^ NW'(1);
				raddr1 = b_next;
			end
			RA_PARENT_SIB: begin
				raddr0 = par ^ NW'(1);
				raddr1 = b_next;
			end
			RA_AB_LOAD: begin
				raddr0 = a_load;
				raddr1 = b_load;
			end
			default: begin
				raddr0 = a_next;
				raddr1 = b_next;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			store[waddr] <= wdata;
		end
		rd0_q <= store[raddr0];
		rd1_q <= store[raddr1];
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_q  <= req.opcode;
			pos_q <= req.position;
			val_q <= req.new_value;
			lo_q  <= req.range_low;
			hi_q  <= req.range_high;
		end
		if (ctl.node_en) begin
			if (ctl.node_sel == NODE_LEAF) begin
				node_q <= leaf_node;
				cur_q  <= val_q;
			end else begin
				node_q <= par;
				cur_q  <= par_val;
			end
		end
		if (ctl.ab_en) begin
			if (ctl.ab_sel == AB_LOAD) begin
				a_q <= a_load;
				b_q <= b_load;
			end else begin
				a_q <= a_next;
				b_q <= b_next;
			end
		end
		if (ctl.best_en) begin
			best_q <= (ctl.best_sel == BEST_INIT) ? EMPTY_VALUE : best_fold;
		end
		if (emit_fire) begin
			rsp_min_q  <= best_q;
			rsp_none_q <= best_q == EMPTY_VALUE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (ctl.clr_en) begin
				clr_q <= clr_q + NW'(1);
			end
			if (emit_fire) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.minimum    = rsp_min_q;
	assign rsp.none_found = rsp_none_q;

	always_comb begin
		status.clr_last    = &clr_q;
		status.in_fire     = in_fire;
		status.is_query    = op_q;
		status.pos_bad     = 32'(pos_q) >= 32'(LEAVES);
		status.leaf_root   = PAD == 1;
		status.parent_root = par == NW'(1);
		status.range_empty = range_empty;
		status.ab_next_ok  = a_next <= b_next;
		status.out_busy    = out_busy;
	end

endmodule

// ===== rtl/strm_checker.sv =====
// ---------------------------------------------------------------------------
// strm_checker
// port-level checks on handshake timing and result consistency
// ---------------------------------------------------------------------------
module strm_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      req_valid,
	input logic                      req_ready,
	input logic                      rsp_valid,
	input logic                      rsp_ready,
	input logic [strm_pkg::VAL_W-1:0] rsp_minimum,
	input logic                      rsp_none_found
);
	import strm_pkg::*;

	// store sweep keeps requests out just after reset
	a_reset_blocks: assert property (@(posedge clk)
		!arst_n |=> !req_ready)
		else $error("request taken straight out of reset");

	// a taken word is decoded before the next one can enter
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("ready high in the cycle after acceptance");

	// no result can appear sooner than decode, set-up and emit allow
	a_no_early_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && !rsp_valid |=> !rsp_valid ##1 !rsp_valid ##1 !rsp_valid)
		else $error("response too soon after acceptance");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=>
			rsp_valid && $stable(rsp_minimum) && $stable(rsp_none_found))
		else $error("stalled response changed");

	a_none_flag: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_none_found == (rsp_minimum == EMPTY_VALUE))
		else $error("none_found disagrees with minimum");

endmodule

bind segment_tree_range_min_top strm_checker u_strm_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (req.valid),
	.req_ready      (req.ready),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_minimum    (rsp.minimum),
	.rsp_none_found (rsp.none_found)
);

// ===== tb/sv/segment_tree_range_min_top_tb.sv =====
// ---------------------------------------------------------------------------
// segment_tree_range_min_top_tb
// self-checking bench for the range-minimum segment tree
// ---------------------------------------------------------------------------
// request words go in through req, and a mirror of the leaf values predicts
// the minimum and the none_found flag of every range query; each rsp word is
// checked field by field against the oldest prediction; directed words cover
// the empty store, extreme positions and values, and empty ranges; random
// traffic with bursts of idling on both sides follows, and the run ends
// with a stretch of back-to-back words
// ---------------------------------------------------------------------------
module segment_tree_range_min_top_tb;
	import strm_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int LEAVES = 1024;

	localparam logic OP_UPDATE = 1'b0;
	localparam logic OP_QUERY  = 1'b1;

	// bound on the whole run: the clearing sweep, then about 1000 words with
	// both sides stalling, with room to spare
	localparam int CYCLE_LIMIT  = 400000;
	// an update keeps the block busy through its climb to the root after acceptance
	localparam int DRAIN_CYCLES = 32;
	localparam int PRINT_CAP    = 100;

	typedef struct {
		logic             opcode;
		logic [POS_W-1:0] position;
		logic [VAL_W-1:0] new_value;
		logic [POS_W-1:0] range_low;
		logic [POS_W-1:0] range_high;
	} req_word_t;

	typedef struct {
		logic [VAL_W-1:0] minimum;
		logic             none_found;
	} min_word_t;

	logic clk;
	logic arst_n;

	strm_req_if req_if ();
	strm_rsp_if rsp_if ();

	segment_tree_range_min_top #(
		.LEAVES(LEAVES)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	// mirror of the leaves and the minimums still owed by the block
	logic [VAL_W-1:0] leaf_mirror [LEAVES];
	min_word_t        expected_minimums [$];

	int unsigned error_count = 0;
	int unsigned cycle_count = 0;
	int unsigned stall_left  = 0;
	bit          idling_enabled = 1'b1;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// watchdog, counts from time zero so the clearing sweep is included
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	task automatic report_mismatch(input string msg);
		if (error_count < PRINT_CAP)
			$display("mismatch at %0t: %s", $realtime, msg);
		error_count++;
	endtask

	// update writes the mirror, query folds the leaves of the clamped range
	function automatic void predict_range_minimum(input req_word_t w);
		min_word_t   r;
		int unsigned hi;
		int unsigned idx;
		if (w.opcode == OP_UPDATE) begin
			// positions past the last leaf leave the store alone
			if (w.position < LEAVES)
				leaf_mirror[w.position] = w.new_value;
		end else begin
			r.minimum = EMPTY_VALUE;
			hi = (w.range_high >= LEAVES) ? LEAVES - 1 : w.range_high;
			// low above high: loop never runs and the result stays empty
			for (idx = w.range_low; idx <= hi; idx++)
				if (leaf_mirror[idx[POS_W-1:0]] < r.minimum)
					r.minimum = leaf_mirror[idx[POS_W-1:0]];
			r.none_found = (r.minimum == EMPTY_VALUE);
			expected_minimums = {expected_minimums, r};
		end
	endfunction

	// rsp checker, sampled at the rising edge
	always @(posedge clk) begin
		min_word_t want;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			if (expected_minimums.size() == 0) begin
				report_mismatch($sformatf("unexpected rsp word minimum=%0d none_found=%0b",
					rsp_if.minimum, rsp_if.none_found));
			end else begin
				want = expected_minimums.pop_front();
				if (rsp_if.minimum !== want.minimum)
					report_mismatch($sformatf("minimum got %0d want %0d",
						rsp_if.minimum, want.minimum));
				if (rsp_if.none_found !== want.none_found)
					report_mismatch($sformatf("none_found got %0b want %0b",
						rsp_if.none_found, want.none_found));
			end
		end
	end

	// rsp back-pressure in random bursts, driven on the falling edge
	always @(negedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			rsp_if.ready <= 1'b0;
		end else if (idling_enabled && $urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(0, 13);
			rsp_if.ready <= 1'b0;
		end else begin
			rsp_if.ready <= 1'b1;
		end
	end

	// called at a falling edge; returns at the falling edge after acceptance
	// with valid still high, so a following word needs no second assignment
	task automatic send_request(input req_word_t w);
		int unsigned gap;
		if (idling_enabled && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 14);
			req_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_if.valid      <= 1'b1;
		req_if.opcode     <= w.opcode;
		req_if.position   <= w.position;
		req_if.new_value  <= w.new_value;
		req_if.range_low  <= w.range_low;
		req_if.range_high <= w.range_high;
		@(posedge clk);
		while (!req_if.ready)
			@(posedge clk);
		predict_range_minimum(w);
		@(negedge clk);
	endtask

	// ignored fields carry random junk so the block must not look at them
	function automatic req_word_t make_update(input int unsigned pos,
			input logic [VAL_W-1:0] val);
		req_word_t w;
		w.opcode     = OP_UPDATE;
		w.position   = POS_W'(pos);
		w.new_value  = val;
		w.range_low  = POS_W'($urandom);
		w.range_high = POS_W'($urandom);
		return w;
	endfunction

	function automatic req_word_t make_query(input int unsigned lo, input int unsigned hi);
		req_word_t w;
		w.opcode     = OP_QUERY;
		w.position   = POS_W'($urandom);
		w.new_value  = VAL_W'($urandom);
		w.range_low  = POS_W'(lo);
		w.range_high = POS_W'(hi);
		return w;
	endfunction

	function automatic req_word_t random_request();
		req_word_t   w;
		int unsigned lo;
		int unsigned hi;
		w = make_update($urandom, VAL_W'($urandom));
		if ($urandom_range(0, 9) < 4) begin
			// hot spots at both ends keep neighbouring leaves in play
			case ($urandom_range(0, 3))
				0: w.position = POS_W'($urandom_range(0, 31));
				1: w.position = POS_W'($urandom_range(LEAVES - 32, LEAVES - 1));
				default: w.position = POS_W'($urandom);
			endcase
			case ($urandom_range(0, 9))
				0: w.new_value = EMPTY_VALUE;
				1: w.new_value = '0;
				2: w.new_value = EMPTY_VALUE - VAL_W'(1);
				3, 4: w.new_value = VAL_W'($urandom_range(0, 255));
				default: w.new_value = VAL_W'($urandom);
			endcase
		end else begin
			lo = $urandom_range(0, LEAVES - 1);
			hi = $urandom_range(0, LEAVES - 1);
			case ($urandom_range(0, 7))
				0: hi = lo;
				1, 2, 3: begin
					hi = lo + $urandom_range(0, 40);
					if (hi > LEAVES - 1)
						hi = LEAVES - 1;
				end
				4: begin
					lo = 0;
					hi = LEAVES - 1;
				end
				// 5: unordered pair, low above high about half the time
				5: ;
				default: begin
					if (lo > hi) begin
						lo = lo ^ hi;
						hi = lo ^ hi;
						lo = lo ^ hi;
					end
				end
			endcase
			w = make_query(lo, hi);
		end
		return w;
	endfunction

	// every range on a freshly cleared store reads as empty
	task automatic test_empty_store();
		send_request(make_query(0, LEAVES - 1));
		send_request(make_query(0, 0));
		send_request(make_query(LEAVES - 1, LEAVES - 1));
		send_request(make_query(600, 7));
	endtask

	// extreme positions and values, overwrite back to empty, inverted range
	// (with 1024 leaves no position lies past the end, so the clamp of the
	// range end and the dropped update cannot be reached from the ports)
	task automatic test_point_updates();
		send_request(make_update(0, '0));
		send_request(make_update(LEAVES - 1, EMPTY_VALUE - VAL_W'(1)));
		send_request(make_update(512, VAL_W'(12345)));
		send_request(make_query(0, LEAVES - 1));
		send_request(make_query(1, LEAVES - 1));
		send_request(make_query(513, LEAVES - 1));
		send_request(make_query(LEAVES - 1, LEAVES - 1));
		send_request(make_update(0, EMPTY_VALUE));
		send_request(make_query(0, 0));
		send_request(make_query(0, 511));
		send_request(make_query(LEAVES - 1, 0));
		send_request(make_update(LEAVES - 1, EMPTY_VALUE));
		send_request(make_update(512, EMPTY_VALUE));
		send_request(make_query(0, LEAVES - 1));
	endtask

	// mixed traffic; idling switched on and off in stretches of 64 words
	task automatic test_random_traffic(input int unsigned count);
		int unsigned n;
		for (n = 0; n < count; n++) begin
			if (n % 64 == 0)
				idling_enabled = ($urandom_range(0, 3) != 0);
			send_request(random_request());
		end
	endtask

	// final stretch with no idling on either side
	task automatic test_back_to_back(input int unsigned count);
		int unsigned n;
		idling_enabled = 1'b0;
		for (n = 0; n < count; n++)
			send_request(random_request());
	endtask

	initial begin
		int unsigned i;
		for (i = 0; i < LEAVES; i++)
			leaf_mirror[i[POS_W-1:0]] = EMPTY_VALUE;

		arst_n            = 1'b0;
		req_if.valid      = 1'b0;
		req_if.opcode     = OP_UPDATE;
		req_if.position   = '0;
		req_if.new_value  = '0;
		req_if.range_low  = '0;
		req_if.range_high = '0;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		// ready stays low through the clearing sweep, send_request waits on it
		@(negedge clk);

		test_empty_store();
		test_point_updates();
		test_random_traffic(880);
		test_back_to_back(100);

		req_if.valid <= 1'b0;
		while (expected_minimums.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
